// ===== design/sle_pkg.sv =====
package sle_pkg;

  // Default number of list entries.
  localparam int unsigned DepthDefault = 64;

  // Field widths of one input item and one result item.
  localparam int unsigned OpW     = 3;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned PosW    = 6;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 7;

  // Operation codes.
  localparam logic [OpW-1:0] OP_INSERT     = 3'd0;
  localparam logic [OpW-1:0] OP_REMOVE_VAL = 3'd1;
  localparam logic [OpW-1:0] OP_REMOVE_IDX = 3'd2;
  localparam logic [OpW-1:0] OP_READ       = 3'd3;
  localparam logic [OpW-1:0] OP_WRITE      = 3'd4;

  // Result status codes.
  localparam logic [StatusW-1:0] STAT_OK        = 2'd0;
  localparam logic [StatusW-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [StatusW-1:0] STAT_RANGE     = 2'd2;
  localparam logic [StatusW-1:0] STAT_FULL      = 2'd3;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic eval;        // register the compare flags against the broadcast value
    logic load;        // take the broadcast value
    logic from_left;   // take the lower neighbour's entry (insert shift)
    logic from_right;  // take the upper neighbour's entry (gap closing)
  } cell_ctrl_t;

endpackage

// ===== design/sle_cell.sv =====
module sle_cell (
  input  logic                              clk_i,
  input  sle_pkg::cell_ctrl_t               ctrl_i,
  input  logic signed [sle_pkg::ValueW-1:0] value_i,
  input  logic        [sle_pkg::ValueW-1:0] left_i,
  input  logic        [sle_pkg::ValueW-1:0] right_i,
  output logic        [sle_pkg::ValueW-1:0] entry_o,
  output logic                              gt_o,
  output logic                              eq_o
);

  logic [sle_pkg::ValueW-1:0] entry_q, entry_d;
  logic                       gt_q, eq_q;

  // Select the new entry: broadcast value, or a neighbour during a shift.
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.load) begin
      entry_d = value_i;
    end else if (ctrl_i.from_left) begin
      entry_d = left_i;
    end else if (ctrl_i.from_right) begin
      entry_d = right_i;
    end
  end

  // Entry storage; its contents are meaningless until written.
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  // Compare flags, registered during the evaluation cycle.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.eval) begin
      gt_q <= $signed(entry_q) > value_i;
      eq_q <= entry_q == value_i;
    end
  end

  assign entry_o = entry_q;
  assign gt_o    = gt_q;
  assign eq_o    = eq_q;

endmodule

// ===== design/sorted_list_engine.sv =====
// An accepted item passes through a compare state in the cell row and then a shift
// state; the shift waits while a result is still held, and the result is registered
// in the output register when the shift commits; no new item is taken before that.
// Reset: asynchronous, active low; empties the list and drops any held result.
// Entry contents are not cleared; only entries below the count are ever used.
module sorted_list_engine #(
  parameter int unsigned DEPTH = sle_pkg::DepthDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic        [sle_pkg::OpW-1:0]     operation_i,
  input  logic signed [sle_pkg::ValueW-1:0]  value_i,
  input  logic        [sle_pkg::PosW-1:0]    position_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic        [sle_pkg::StatusW-1:0] status_o,
  output logic signed [sle_pkg::ValueW-1:0]  read_data_o,
  output logic        [sle_pkg::CountW-1:0]  count_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EVAL  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  logic [1:0] state_q, state_d;

  logic        [sle_pkg::OpW-1:0]    op_q;
  logic signed [sle_pkg::ValueW-1:0] val_q;
  logic        [sle_pkg::PosW-1:0]   pos_q;

  logic [CntW-1:0] cnt_q, cnt_d;

  logic                               out_valid_q;
  logic        [sle_pkg::StatusW-1:0] status_q, status_d;
  logic signed [sle_pkg::ValueW-1:0]  rdata_q, rdata_d;

  logic in_fire, apply_fire;

  sle_pkg::cell_ctrl_t        ctrl [DEPTH];
  logic [sle_pkg::ValueW-1:0] entry [DEPTH];
  logic [DEPTH-1:0]           gt_vec, eq_vec;

  logic [DEPTH-1:0] valid_vec, idx_after, idx_sel;
  logic [DEPTH-1:0] ins_src, ins_first, ins_after;
  logic [DEPTH-1:0] rem_src, rem_first, rem_after;
  logic             full, pos_ok, found;
  logic [sle_pkg::ValueW-1:0] sel_data;

  assign in_ready_o = state_q == S_IDLE;
  assign in_fire    = in_valid_i && in_ready_o;
  assign apply_fire = (state_q == S_APPLY) && (!out_valid_q || out_ready_i);

  // Sequencer: accept, compare in the cells, then commit the shift.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_fire) state_d = S_EVAL;
      S_EVAL:  state_d = S_APPLY;
      S_APPLY: if (apply_fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the accepted item.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= operation_i;
      val_q <= value_i;
      pos_q <= position_i;
    end
  end

  // Position masks and the occupancy thermometer.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      valid_vec[i] = i < int'(cnt_q);
      idx_after[i] = i >= int'(pos_q);
      idx_sel[i]   = i == int'(pos_q);
    end
  end

  assign full   = cnt_q == CntW'(DEPTH);
  assign pos_ok = int'(pos_q) < int'(cnt_q);

  // Insert point: the first greater entry, or the first free slot.
  assign ins_src   = (gt_vec & valid_vec) | ~valid_vec;
  assign ins_first = ins_src & (~ins_src + DEPTH'(1));
  assign ins_after = ~(ins_first - DEPTH'(1));

  // Removal point: the first equal entry.
  assign rem_src   = eq_vec & valid_vec;
  assign rem_first = rem_src & (~rem_src + DEPTH'(1));
  assign rem_after = ~(rem_first - DEPTH'(1));
  assign found     = |rem_src;

  // Read selection across the row.
  always_comb begin
    sel_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (idx_sel[i]) sel_data = sel_data | entry[i];
    end
  end

  // Per-cell control and the result of the operation.
  always_comb begin
    status_d = sle_pkg::STAT_OK;
    rdata_d  = '0;
    cnt_d    = cnt_q;
    for (int i = 0; i < DEPTH; i++) begin
      ctrl[i]      = '0;
      ctrl[i].eval = state_q == S_EVAL;
    end
    case (op_q)
      sle_pkg::OP_INSERT: begin
        if (full) begin
          status_d = sle_pkg::STAT_FULL;
        end else begin
          cnt_d = cnt_q + CntW'(1);
          for (int i = 0; i < DEPTH; i++) begin
            ctrl[i].load      = apply_fire && ins_first[i];
            ctrl[i].from_left = apply_fire && ins_after[i] && !ins_first[i];
          end
        end
      end
      sle_pkg::OP_REMOVE_VAL: begin
        if (!found) begin
          status_d = sle_pkg::STAT_NOT_FOUND;
        end else begin
          cnt_d = cnt_q - CntW'(1);
          for (int i = 0; i < DEPTH; i++) begin
            ctrl[i].from_right = apply_fire && rem_after[i];
          end
        end
      end
      sle_pkg::OP_REMOVE_IDX: begin
        if (!pos_ok) begin
          status_d = sle_pkg::STAT_RANGE;
        end else begin
          cnt_d = cnt_q - CntW'(1);
          for (int i = 0; i < DEPTH; i++) begin
            ctrl[i].from_right = apply_fire && idx_after[i];
          end
        end
      end
      sle_pkg::OP_READ: begin
        if (!pos_ok) begin
          status_d = sle_pkg::STAT_RANGE;
        end else begin
          rdata_d = sel_data;
        end
      end
      sle_pkg::OP_WRITE: begin
        if (!pos_ok) begin
          status_d = sle_pkg::STAT_RANGE;
        end else begin
          for (int i = 0; i < DEPTH; i++) begin
            ctrl[i].load = apply_fire && idx_sel[i];
          end
        end
      end
      default: ;
    endcase
  end

  // Row of entry cells; each neighbour link carries one entry per cycle while a shift commits.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [sle_pkg::ValueW-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = entry[g];
    end else begin : g_mid_l
      assign left_w = entry[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = entry[g];
    end else begin : g_mid_r
      assign right_w = entry[g+1];
    end
    sle_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl[g]),
      .value_i (val_q),
      .left_i  (left_w),
      .right_i (right_w),
      .entry_o (entry[g]),
      .gt_o    (gt_vec[g]),
      .eq_o    (eq_vec[g])
    );
  end

  // Entry count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (apply_fire) begin
      cnt_q <= cnt_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (apply_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (apply_fire) begin
      status_q <= status_d;
      rdata_q  <= rdata_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign read_data_o = rdata_q;
  assign count_o     = sle_pkg::CountW'(cnt_q);

endmodule

// ===== design/sle_chk.sv =====
module sle_chk #(
  parameter int unsigned DEPTH = sle_pkg::DepthDefault
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic        [sle_pkg::StatusW-1:0] status_o,
  input logic signed [sle_pkg::ValueW-1:0]  read_data_o,
  input logic        [sle_pkg::CountW-1:0]  count_o
);

  // A full status only ever comes with a full list.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == sle_pkg::STAT_FULL |-> count_o == sle_pkg::CountW'(DEPTH))
    else $error("full status with a list that is not full");

  // Read data is zero for every result whose status is not OK.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != sle_pkg::STAT_OK |-> read_data_o == '0)
    else $error("read data set on a failed operation");

  // The engine takes no new item in the cycle after accepting one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while an item is in progress");

  // A result that has not been taken holds still.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(status_o) && $stable(read_data_o) && $stable(count_o))
    else $error("stalled result changed");

endmodule

bind sorted_list_engine sle_chk #(.DEPTH(DEPTH)) u_sle_chk (.*);
